FILE: hw/rtl/tdpc_pkg.sv
// Package for the trial-division prime counter.
// Holds the item types on both channels and the sequencer state type.
// No dependencies.
package tdpc_pkg;

  // Fixed field widths of the channels
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_OUT_W = 32;

  // Input item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_of_set;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                   is_prime;
    logic [COUNT_OUT_W-1:0] prime_count;
  } out_item_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/trial_division_prime_counter_top.sv
// Trial-division prime counter, top level.
// Uses tdpc_pkg for channel item types and the sequencer state type.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one number with a
//   last_of_set flag; out channel (out_valid/out_ready/out_data) returns
//   one item per number: the prime flag and the running prime count of
//   the current set, including this number, saturating at its maximum.
//   The item flagged last_of_set closes the set; the count restarts at
//   zero for the next number.
// Timing:
//   Values below two and even values go from idle straight to finish.
//   Odd values try odd divisors from 3 upward while d*d <= value;
//   each divisor takes one bound check plus a restoring remainder of
//   one bit per cycle through a single shared subtractor.
//   One number is in work at a time; in_ready is high only when idle,
//   which starts the cycle after the result is loaded.
// Reset and stalls:
//   Synchronous reset clears the sequencer, the count and out_valid.
//   A finished result waits in the output register; the next number is
//   accepted meanwhile, and its result waits until the register frees.
module trial_division_prime_counter_top #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tdpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tdpc_pkg::out_item_t out_data
);

  localparam int unsigned SQ_W  = VALUE_BITS + 2;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  tdpc_pkg::state_t state, state_next;

  logic [VALUE_BITS-1:0] val;        // number under test
  logic                  last;       // set closes after this item
  logic [VALUE_BITS-1:0] divisor;    // current odd trial divisor
  logic [SQ_W-1:0]       sq;         // divisor squared
  logic [VALUE_BITS-1:0] rem;        // partial remainder
  logic [VALUE_BITS-1:0] dividend;   // shifts out one bit per step
  logic [CNT_W-1:0]      cnt;        // remaining remainder steps
  logic                  prime;      // decision for the item
  logic [COUNT_BITS-1:0] count;      // primes in the current set

  logic [VALUE_BITS-1:0] val_in;
  logic                  trivial_prime;
  logic                  trivial_composite;
  logic                  sq_above;
  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS+1:0] diff;
  logic [VALUE_BITS-1:0] rem_step;
  logic                  div_last;
  logic                  load_out;
  logic [COUNT_BITS-1:0] count_inc;

  // Input value fitted to the working width
  assign val_in = VALUE_BITS'({{VALUE_BITS{1'b0}}, in_data.value});

  // Cases settled without any division
  assign trivial_prime     = (val_in == VALUE_BITS'(2));
  assign trivial_composite = (val_in < VALUE_BITS'(2)) || !val_in[0];

  // Bound check: stop once the divisor squared exceeds the value
  assign sq_above = (sq > {2'b00, val});

  // Shared subtractor: one restoring remainder step
  assign rem_shift = {rem, dividend[VALUE_BITS-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, divisor};
  assign rem_step  = diff[VALUE_BITS+1] ? rem_shift[VALUE_BITS-1:0]
                                        : diff[VALUE_BITS-1:0];
  assign div_last  = (cnt == '0);

  // Saturating count including this item
  assign count_inc = (prime && (count != {COUNT_BITS{1'b1}})) ? count + COUNT_BITS'(1)
                                                              : count;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tdpc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (trivial_prime || trivial_composite) begin
            state_next = tdpc_pkg::ST_FINISH;
          end else begin
            state_next = tdpc_pkg::ST_CHECK;
          end
        end
      end
      tdpc_pkg::ST_CHECK: begin
        state_next = sq_above ? tdpc_pkg::ST_FINISH : tdpc_pkg::ST_DIVIDE;
      end
      tdpc_pkg::ST_DIVIDE: begin
        if (div_last) begin
          state_next = (rem_step == '0) ? tdpc_pkg::ST_FINISH : tdpc_pkg::ST_CHECK;
        end
      end
      tdpc_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = tdpc_pkg::ST_IDLE;
        end
      end
      default: state_next = tdpc_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      tdpc_pkg::ST_IDLE:   in_ready = 1'b1;
      tdpc_pkg::ST_FINISH: load_out = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdpc_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
        count     <= last ? '0 : count_inc;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      tdpc_pkg::ST_IDLE: begin
        if (in_valid) begin
          val     <= val_in;
          last    <= in_data.last_of_set;
          prime   <= trivial_prime;
          divisor <= VALUE_BITS'(3);
          sq      <= SQ_W'(9);
        end
      end
      tdpc_pkg::ST_CHECK: begin
        // Bound passed without a factor: prime
        prime    <= sq_above;
        rem      <= '0;
        dividend <= val;
        cnt      <= CNT_W'(VALUE_BITS - 1);
      end
      tdpc_pkg::ST_DIVIDE: begin
        rem      <= rem_step;
        dividend <= {dividend[VALUE_BITS-2:0], 1'b0};
        cnt      <= cnt - CNT_W'(1);
        if (div_last) begin
          // (d+2)^2 = d^2 + 4d + 4
          sq      <= sq + SQ_W'({divisor, 2'b00}) + SQ_W'(4);
          divisor <= divisor + VALUE_BITS'(2);
          prime   <= 1'b0;
        end
      end
      tdpc_pkg::ST_FINISH: begin
        if (load_out) begin
          out_data.is_prime    <= prime;
          out_data.prime_count <=
            tdpc_pkg::COUNT_OUT_W'({{tdpc_pkg::COUNT_OUT_W{1'b0}}, count_inc});
        end
      end
      default: begin
        prime <= 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/tdpc_checker.sv
// Port-level checker for the trial-division prime counter.
// Uses tdpc_pkg item types; bound to trial_division_prime_counter_top.
module tdpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input tdpc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input tdpc_pkg::out_item_t out_data
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: no new item right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // A result appears as the sequencer returns to idle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result not aligned with end of work");

  // Each item passes through a working state before its result shows
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result in the cycle after accept");

  // Nothing is pending after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind trial_division_prime_counter_top tdpc_checker u_tdpc_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for trial_division_prime_counter_top: directed and random numbers,
// with a built-in primality and set-count predictor checked against every result item.
// Depends on tdpc_pkg and the top level RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_GOAL  = 290;
  localparam int          MAX_REPORTS  = 10;
  localparam int          SETTLE_CYCLES = 40;
  // Watchdog limit; room for far more than 290 slowest-case items plus stalls
  localparam int          CYCLE_LIMIT  = 2_500_000;
  localparam logic [31:0] COUNT_SAT    = '1;

  // Idle percentages per traffic phase
  typedef enum logic [1:0] {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_FULL_RATE
  } traffic_phase_t;

  typedef struct {
    tdpc_pkg::in_item_t item;
    bit                 wait_for_drain;
  } pending_number_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  tdpc_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tdpc_pkg::out_item_t out_data;

  pending_number_t     pending_numbers[$];
  tdpc_pkg::out_item_t expected_verdicts[$];
  logic [31:0]         set_prime_total = '0;
  int                  planned_total = 0;
  int                  numbers_sent = 0;
  int                  numbers_accepted = 0;
  int                  results_checked = 0;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;

  trial_division_prime_counter_top DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Primality by odd trial divisors with an exact square bound
  function automatic bit trial_prime(logic [tdpc_pkg::VALUE_W-1:0] v);
    int unsigned n;
    int unsigned d;
    n = v;
    if (n == 2) return 1'b1;
    if (n < 2 || n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Verdict for one number; advances the per-set prime total
  function automatic tdpc_pkg::out_item_t predict_verdict(tdpc_pkg::in_item_t num);
    tdpc_pkg::out_item_t verdict;
    verdict.is_prime = trial_prime(num.value);
    if (verdict.is_prime && set_prime_total != COUNT_SAT) set_prime_total++;
    verdict.prime_count = set_prime_total;
    if (num.last_of_set) set_prime_total = '0;
    return verdict;
  endfunction

  function automatic traffic_phase_t current_phase();
    if (numbers_sent < planned_total / 3) return PH_SLOW_SINK;
    if (numbers_sent < (2 * planned_total) / 3) return PH_SLOW_SOURCE;
    return PH_FULL_RATE;
  endfunction

  function automatic int source_idle_pct(traffic_phase_t ph);
    case (ph)
      PH_SLOW_SINK:   return 26;
      PH_SLOW_SOURCE: return 84;
      default:        return 0;
    endcase
  endfunction

  function automatic int sink_idle_pct(traffic_phase_t ph);
    case (ph)
      PH_SLOW_SINK:   return 84;
      PH_SLOW_SOURCE: return 26;
      default:        return 0;
    endcase
  endfunction

  function automatic void add_number(int unsigned v, bit last, bit drain);
    pending_number_t p;
    p.item.value       = v[tdpc_pkg::VALUE_W-1:0];
    p.item.last_of_set = last;
    p.wait_for_drain   = drain;
    pending_numbers.push_back(p);
  endfunction

  // Mostly small numbers keep the run short; some span the full range
  function automatic int unsigned draw_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(2047);
    if (pick < 70) return $urandom_range(63);
    if (pick < 85) return $urandom_range(2047) | 1;
    return $urandom_range(65535);
  endfunction

  function automatic void flag_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endfunction

  // Source side: offers the queued numbers, idling and draining on request
  always @(posedge clk) begin
    bit              next_valid;
    int              owed;
    pending_number_t head;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      owed = numbers_accepted - results_checked + int'(in_valid && in_ready)
             - int'(out_valid && out_ready);
      next_valid = 1'b0;
      if (pending_numbers.size() != 0) begin
        head = pending_numbers[0];
        if (!(head.wait_for_drain && owed != 0) &&
            $urandom_range(99) >= source_idle_pct(current_phase())) begin
          void'(pending_numbers.pop_front());
          in_data      <= head.item;
          next_valid   = 1'b1;
          numbers_sent <= numbers_sent + 1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Sink side: random back-pressure on the result channel
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct(current_phase()));
    end
  end

  // Observer: check each result item first, then predict for a newly accepted number
  always @(posedge clk) begin
    tdpc_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch($sformatf("unexpected result is_prime=%0b prime_count=%0d",
                                  out_data.is_prime, out_data.prime_count));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.is_prime !== want.is_prime)
            flag_mismatch($sformatf("result %0d is_prime expected %0b got %0b",
                                    results_checked, want.is_prime, out_data.is_prime));
          if (out_data.prime_count !== want.prime_count)
            flag_mismatch($sformatf("result %0d prime_count expected %0d got %0d",
                                    results_checked, want.prime_count,
                                    out_data.prime_count));
        end
        results_checked <= results_checked + 1;
      end
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(predict_verdict(in_data));
        numbers_accepted <= numbers_accepted + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus list, reset and end of run
  initial begin
    int set_len;
    int k;
    // Extremes, small cases and square bounds; sets of one and longer sets
    add_number(0, 0, 0);
    add_number(1, 0, 0);
    add_number(2, 0, 0);
    add_number(3, 0, 0);
    add_number(4, 0, 0);
    add_number(5, 0, 0);
    add_number(9, 1, 0);      // 3*3: divisor square equals the value
    add_number(25, 1, 0);
    add_number(7, 1, 0);      // set of one, closed on a prime
    add_number(49, 0, 0);
    add_number(63001, 0, 0);  // 251*251
    add_number(65521, 0, 0);  // largest 16-bit prime
    add_number(65535, 0, 0);
    add_number(65534, 0, 0);
    add_number(32768, 0, 0);
    add_number(32767, 1, 0);  // set closed on a composite
    add_number(32749, 0, 0);
    add_number(21845, 0, 0);
    add_number(43690, 0, 0);
    add_number(2, 1, 0);
    add_number(8191, 0, 0);
    add_number(1, 1, 0);
    // Random sets; the first random number and number 170 wait for all results to drain
    k = 0;
    while (pending_numbers.size() < RANDOM_GOAL) begin
      set_len = $urandom_range(1, 12);
      for (int i = 0; i < set_len; i++) begin
        add_number(draw_value(), i == set_len - 1, k == 0 || k == 170);
        k++;
      end
    end
    planned_total = pending_numbers.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (results_checked < planned_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tdpc_pkg.sv
hw/rtl/trial_division_prime_counter_top.sv
hw/rtl/tdpc_checker.sv
bench/tb_top.sv
